### src/ibos_pkg.sv
// ----------------------------------------------------------------------------
// ibos_pkg
// Shared types and constants for the interval best-overlap search unit.
// ----------------------------------------------------------------------------
package ibos_pkg;

  localparam int ChromW   = 8;
  localparam int CoordW   = 31;
  localparam int StrandW  = 2;
  localparam int FuncW    = 2;
  localparam int IndexW   = 10;
  localparam int RatioW   = 16;
  localparam int RadiusW  = 8;
  localparam int LenW     = CoordW + 1;
  localparam int DivCntW  = $clog2(RatioW);

  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(50);

  // Word index of the window radius register
  localparam logic REG_WINDOW_RADIUS = 1'b0;

  localparam logic [FuncW-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FuncW-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [FuncW-1:0] FUNC_NOP    = 2'd3;

  typedef struct packed {
    logic [ChromW-1:0]  chrom;
    logic [CoordW-1:0]  start_pos;
    logic [CoordW-1:0]  end_pos;
    logic [StrandW-1:0] strand;
  } entry_t;

  typedef struct packed {
    logic load_query;
    logic append;
    logic clear;
    logic srch_upd;
    logic scan_init;
    logic scan_issue;
    logic div_init;
    logic div_sel;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_search;
    logic srch_more;
    logic scan_last;
    logic div_last;
    logic out_busy;
  } dp_sts_t;

endpackage

### src/ibos_if.sv
// ----------------------------------------------------------------------------
// ibos_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ibos_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  chrom_id;
  logic [30:0] item_start;
  logic [30:0] item_end;
  logic [1:0]  item_strand;
  logic        single_block;

  modport source (output valid, func, chrom_id, item_start, item_end, item_strand,
                  single_block, input ready);
  modport sink (input valid, func, chrom_id, item_start, item_end, item_strand,
                single_block, output ready);
endinterface

interface ibos_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [9:0]  entry_index;
  logic [1:0]  entry_strand;
  logic [30:0] overlap_length;
  logic [15:0] ratio_of_query;
  logic [15:0] ratio_of_entry;

  modport source (output valid, hit, entry_index, entry_strand, overlap_length,
                  ratio_of_query, ratio_of_entry, input ready);
  modport sink (input valid, hit, entry_index, entry_strand, overlap_length,
                ratio_of_query, ratio_of_entry, output ready);
endinterface

### src/ibos_dp.sv
// ----------------------------------------------------------------------------
// ibos_dp
// Datapath: interval table, search and scan registers, divider, result reg.
// ----------------------------------------------------------------------------
module ibos_dp import ibos_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_sts_t             sts,
  input  logic [RadiusW-1:0]  window_radius,
  input  logic [ChromW-1:0]   chrom_id,
  input  logic [CoordW-1:0]   item_start,
  input  logic [CoordW-1:0]   item_end,
  input  logic [StrandW-1:0]  item_strand,
  input  logic                single_block,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic [IndexW-1:0]   entry_index,
  output logic [StrandW-1:0]  entry_strand,
  output logic [CoordW-1:0]   overlap_length,
  output logic [RatioW-1:0]   ratio_of_query,
  output logic [RatioW-1:0]   ratio_of_entry
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = ((IW > RadiusW) ? IW : RadiusW) + 1;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data;
  logic [IW-1:0]      rd_addr;
  logic [CW-1:0]      count;
  logic               full;

  logic [ChromW-1:0]  q_chrom;
  logic [CoordW-1:0]  q_start;
  logic [CoordW-1:0]  q_end;
  logic               q_single;

  logic [IW-1:0]      lo;
  logic [IW-1:0]      hi;
  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;
  logic               after;

  logic [AW-1:0]      base_w;
  logic [AW-1:0]      rad_w;
  logic [AW-1:0]      first_w;
  logic [AW-1:0]      last_raw;
  logic [AW-1:0]      top_w;
  logic [AW-1:0]      last_w;
  logic [IW-1:0]      cursor;
  logic [IW-1:0]      last;

  logic               eval_v;
  logic [IW-1:0]      eval_idx;
  logic               match;
  logic [CoordW-1:0]  ms;
  logic [CoordW-1:0]  me;
  logic [CoordW-1:0]  ov;

  logic               best_found;
  logic [IW-1:0]      best_idx;
  logic [CoordW-1:0]  best_ov;
  logic [CoordW-1:0]  best_start;
  logic [CoordW-1:0]  best_end;
  logic [StrandW-1:0] best_strand;

  logic [LenW-1:0]    qlen;
  logic [LenW-1:0]    elen;
  logic [LenW:0]      rem;
  logic [LenW-1:0]    den;
  logic [RatioW-1:0]  quo;
  logic [DivCntW-1:0] div_cnt;
  logic               div_sel_r;
  logic [LenW:0]      shifted;
  logic               ge;
  logic [RatioW-1:0]  quo_next;
  logic [RatioW-1:0]  ratio_q;
  logic [RatioW-1:0]  ratio_e;

  assign full    = (count == CW'(TABLE_DEPTH));
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IW:1];
  assign rd_addr = cmd.scan_issue ? cursor : mid;

  // Entry sorts after the query: greater chromosome, or same and later start
  assign after = (rd_data.chrom > q_chrom) ||
                 ((rd_data.chrom == q_chrom) && (rd_data.start_pos > q_start));

  // Window bounds, clamped to the loaded part of the table
  assign base_w   = AW'(lo);
  assign rad_w    = AW'(window_radius);
  assign first_w  = (base_w >= rad_w) ? (base_w - rad_w) : '0;
  assign last_raw = base_w + rad_w;
  assign top_w    = AW'(count) - AW'(1);
  assign last_w   = (last_raw > top_w) ? top_w : last_raw;

  // A reversed query can pass the disjoint test with min end <= max start;
  // only a positive overlap counts
  assign match = eval_v && (rd_data.chrom == q_chrom) &&
                 !((q_end <= rd_data.start_pos) || (q_start >= rd_data.end_pos)) &&
                 (me > ms);
  assign ms = (q_start > rd_data.start_pos) ? q_start : rd_data.start_pos;
  assign me = (q_end < rd_data.end_pos) ? q_end : rd_data.end_pos;
  assign ov = me - ms;

  assign qlen = {1'b0, q_end} - {1'b0, q_start} + LenW'(1);
  assign elen = {1'b0, best_end} - {1'b0, best_start} + LenW'(1);

  // Restoring division, one quotient bit a step; overlap < length so the
  // quotient fits in RatioW bits
  assign shifted  = {rem[LenW-1:0], 1'b0};
  assign ge       = (shifted >= {1'b0, den});
  assign quo_next = {quo[RatioW-2:0], ge};

  assign sts.no_search = !q_single || (count == '0);
  assign sts.srch_more = ((hi - lo) > IW'(1));
  assign sts.scan_last = (cursor == last);
  assign sts.div_last  = (div_cnt == DivCntW'(RatioW - 1));
  assign sts.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count[IW-1:0]] <= '{chrom: chrom_id, start_pos: item_start,
                              end_pos: item_end, strand: item_strand};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      eval_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && !full) begin
        count <= count + CW'(1);
      end
      eval_v <= cmd.scan_issue;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_chrom    <= chrom_id;
      q_start    <= item_start;
      q_end      <= item_end;
      q_single   <= single_block;
      lo         <= '0;
      hi         <= (count == '0) ? '0 : IW'(count - CW'(1));
      best_found <= 1'b0;
      best_ov    <= '0;
    end else begin
      if (cmd.srch_upd) begin
        if (after) begin
          hi <= mid;
        end else begin
          lo <= mid;
        end
      end
      if (match && (ov > best_ov)) begin
        best_found  <= 1'b1;
        best_ov     <= ov;
        best_idx    <= eval_idx;
        best_start  <= rd_data.start_pos;
        best_end    <= rd_data.end_pos;
        best_strand <= rd_data.strand;
      end
    end

    if (cmd.scan_init) begin
      cursor <= first_w[IW-1:0];
      last   <= last_w[IW-1:0];
    end else if (cmd.scan_issue) begin
      cursor <= cursor + IW'(1);
    end
    eval_idx <= cursor;

    if (cmd.div_init) begin
      rem       <= {2'b00, best_ov};
      den       <= cmd.div_sel ? elen : qlen;
      quo       <= '0;
      div_cnt   <= '0;
      div_sel_r <= cmd.div_sel;
    end else if (cmd.div_step) begin
      rem     <= ge ? (shifted - {1'b0, den}) : shifted;
      quo     <= quo_next;
      div_cnt <= div_cnt + DivCntW'(1);
    end
    if (cmd.div_step && sts.div_last) begin
      if (div_sel_r) begin
        ratio_e <= quo_next;
      end else begin
        ratio_q <= quo_next;
      end
    end

    if (cmd.out_load) begin
      hit            <= best_found;
      entry_index    <= best_found ? IndexW'(best_idx) : '0;
      entry_strand   <= best_found ? best_strand : '0;
      overlap_length <= best_found ? best_ov : '0;
      ratio_of_query <= best_found ? ratio_q : '0;
      ratio_of_entry <= best_found ? ratio_e : '0;
    end
  end

endmodule

### src/ibos_ctrl.sv
// ----------------------------------------------------------------------------
// ibos_ctrl
// Sequencer: request decode, binary search, window scan, divisions, result.
// ----------------------------------------------------------------------------
module ibos_ctrl import ibos_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [FuncW-1:0]  req_func,
  output logic              req_ready,
  input  dp_sts_t           sts,
  output ctrl_cmd_t         cmd
);

  typedef enum logic [3:0] {
    IDLE, SRCH_CHK, SRCH_RD, SRCH_CMP, SCAN_SET, SCAN, SCAN_DRAIN,
    DIV_SETUP, DIV_Q, DIV_E, RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (req_valid) begin
          case (req_func)
            FUNC_QUERY: begin
              cmd.load_query = 1'b1;
              state_next     = SRCH_CHK;
            end
            FUNC_APPEND: cmd.append = 1'b1;
            FUNC_CLEAR:  cmd.clear  = 1'b1;
            default: ;
          endcase
        end
      end
      SRCH_CHK: begin
        if (sts.no_search) begin
          state_next = RESULT;
        end else if (sts.srch_more) begin
          state_next = SRCH_RD;
        end else begin
          state_next = SCAN_SET;
        end
      end
      SRCH_RD: state_next = SRCH_CMP;
      SRCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_next   = SRCH_CHK;
      end
      SCAN_SET: begin
        cmd.scan_init = 1'b1;
        state_next    = SCAN;
      end
      SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = SCAN_DRAIN;
        end
      end
      SCAN_DRAIN: state_next = DIV_SETUP;
      DIV_SETUP: begin
        cmd.div_init = 1'b1;
        state_next   = DIV_Q;
      end
      DIV_Q: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.div_init = 1'b1;
          cmd.div_sel  = 1'b1;
          state_next   = DIV_E;
        end
      end
      DIV_E: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = RESULT;
        end
      end
      RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/interval_best_overlap_search_unit.sv
// ----------------------------------------------------------------------------
// interval_best_overlap_search_unit
// Sorted interval table with best-overlap query against a search window.
// ----------------------------------------------------------------------------
// Use:
//   req carries one transaction per request: func selects append entry,
//   query or clear table (func 3 is dropped). Append and clear finish in the
//   cycle they are taken and give no result; req is ready again next cycle.
//   A query gives exactly one transaction on rsp.
//   A query runs setup, a binary search of up to ceil(log2(entries)) probes
//   (10 for a full table), a scan of one window entry per cycle (up to
//   2*radius+1 reads of the single memory read port) and a drain, then two
//   divisions in the shared bit-serial divider (one for each ratio) and a
//   load of the result register. Multi-block queries and an empty table skip
//   the search, scan and divisions and go straight to the result state.
//   The result sits in an output register, so a new request is taken while
//   an earlier result waits; a query only stalls at its end while rsp is held.
//   Reset empties the table (entry count to zero, entries left as they are)
//   and sets window_radius to 50. window_radius is written over APB at byte
//   address 0 only while the unit is idle: a user rule the block leaves unchecked.
// ----------------------------------------------------------------------------
module interval_best_overlap_search_unit import ibos_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  ibos_req_if.sink    req,
  ibos_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t          cmd;
  dp_sts_t            sts;
  logic [RadiusW-1:0] window_radius;
  logic               cfg_wr;

  // APB: always ready, register decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_WINDOW_RADIUS) ? {24'd0, window_radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_radius <= RadiusReset;
    end else if (cfg_wr && (paddr[2] == REG_WINDOW_RADIUS)) begin
      window_radius <= pwdata[RadiusW-1:0];
    end
  end

  ibos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ibos_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .window_radius  (window_radius),
    .chrom_id       (req.chrom_id),
    .item_start     (req.item_start),
    .item_end       (req.item_end),
    .item_strand    (req.item_strand),
    .single_block   (req.single_block),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .hit            (rsp.hit),
    .entry_index    (rsp.entry_index),
    .entry_strand   (rsp.entry_strand),
    .overlap_length (rsp.overlap_length),
    .ratio_of_query (rsp.ratio_of_query),
    .ratio_of_entry (rsp.ratio_of_entry)
  );

  // A result appears only from a load by the sequencer
  a_rsp_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("pending result overwritten");

  // A query holds off the next request
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.func == FUNC_QUERY)) |=> !req.ready)
    else $error("request taken during a query");

endmodule

### bench/interval_best_overlap_search_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_best_overlap_search_unit_tb
// Loads mostly sorted interval tables, fires queries at them under random idling
// on both channels and checks every result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module interval_best_overlap_search_unit_tb;
  import ibos_pkg::*;

  localparam int Depth = 1024;
  localparam logic [CoordW-1:0] CoordMax = {CoordW{1'b1}};

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [ChromW-1:0]  chrom;
    logic [CoordW-1:0]  start_pos;
    logic [CoordW-1:0]  end_pos;
    logic [StrandW-1:0] strand;
    logic               single;
  } query_item_t;

  typedef struct packed {
    logic               hit;
    logic [IndexW-1:0]  index;
    logic [StrandW-1:0] strand;
    logic [CoordW-1:0]  overlap;
    logic [RatioW-1:0]  ratio_q;
    logic [RatioW-1:0]  ratio_e;
  } overlap_res_t;

  // directed row: item plus a flag for a typed-in no-hit result
  typedef struct packed {
    query_item_t item;
    logic        typed_miss;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ibos_req_if req ();
  ibos_rsp_if rsp ();

  interval_best_overlap_search_unit #(.TABLE_DEPTH(Depth)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: shadow of the interval table and the radius
  logic [ChromW-1:0]  tbl_chrom  [Depth];
  logic [CoordW-1:0]  tbl_start  [Depth];
  logic [CoordW-1:0]  tbl_end    [Depth];
  logic [StrandW-1:0] tbl_strand [Depth];
  int unsigned        tbl_count;
  int unsigned        radius;

  overlap_res_t pending_res[$];
  int  errors;
  int  burst_left;
  bit  hold_start;

  function automatic logic [RatioW-1:0] q16(longint num, longint len);
    if (len <= 0 || num <= 0) return '0;
    return RatioW'((longint'(num) << 16) / len);
  endfunction

  // Applies one transaction to the shadow state; returns 1 when a result follows
  function automatic bit predict_overlap(input query_item_t it, output overlap_res_t r);
    longint lo, hi, mid, base, idx, es, ee, ms, me, ov, best_ov, best_idx;
    bit after;
    r = '0;
    best_ov = 0;
    best_idx = -1;
    case (it.func)
      FUNC_APPEND: begin
        if (tbl_count < Depth) begin
          tbl_chrom[tbl_count]  = it.chrom;
          tbl_start[tbl_count]  = it.start_pos;
          tbl_end[tbl_count]    = it.end_pos;
          tbl_strand[tbl_count] = it.strand;
          tbl_count++;
        end
        return 1'b0;
      end
      FUNC_CLEAR: begin
        tbl_count = 0;
        return 1'b0;
      end
      FUNC_QUERY: ;
      default: return 1'b0;
    endcase
    if (!it.single || tbl_count == 0) return 1'b1;
    lo = 0;
    hi = longint'(tbl_count) - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (tbl_chrom[mid] != it.chrom) after = tbl_chrom[mid] > it.chrom;
      else after = tbl_start[mid] > it.start_pos;
      if (after) hi = mid;
      else lo = mid;
    end
    base = lo;
    for (longint j = -longint'(radius); j <= longint'(radius); j++) begin
      idx = base + j;
      if (idx < 0 || idx >= longint'(tbl_count)) continue;
      if (tbl_chrom[idx] != it.chrom) continue;
      es = tbl_start[idx];
      ee = tbl_end[idx];
      if (longint'(it.end_pos) <= es || longint'(it.start_pos) >= ee) continue;
      ms = longint'(it.start_pos) > es ? longint'(it.start_pos) : es;
      me = longint'(it.end_pos) < ee ? longint'(it.end_pos) : ee;
      ov = me - ms;
      if (ov > best_ov) begin
        best_ov = ov;
        best_idx = idx;
      end
    end
    if (best_idx >= 0) begin
      r.hit     = 1'b1;
      r.index   = IndexW'(best_idx);
      r.strand  = tbl_strand[best_idx];
      r.overlap = CoordW'(best_ov);
      r.ratio_q = q16(best_ov, longint'(it.end_pos) - longint'(it.start_pos) + 1);
      r.ratio_e = q16(best_ov, longint'(tbl_end[best_idx]) - longint'(tbl_start[best_idx]) + 1);
    end
    return 1'b1;
  endfunction

  // Offer one transaction; sender idles in bursts with random gaps between them.
  // Entered and left at a rising edge.
  task automatic send_item(input query_item_t it, input bit typed_miss);
    overlap_res_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid        <= 1'b1;
    req.func         <= it.func;
    req.chrom_id     <= it.chrom;
    req.item_start   <= it.start_pos;
    req.item_end     <= it.end_pos;
    req.item_strand  <= it.strand;
    req.single_block <= it.single;
    // ready sampled mid-cycle; the transaction lands on the next rising edge
    do @(negedge clk); while (!req.ready);
    if (predict_overlap(it, r)) begin
      pending_res.insert(pending_res.size(), typed_miss ? overlap_res_t'('0) : r);
    end
    @(posedge clk);
  endtask

  // Wait for every result, then let trailing work settle
  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // APB write of the radius, then a read back; only while idle
  task automatic set_radius(input logic [RadiusW-1:0] val);
    logic [31:0] word;
    word = {24'($urandom_range(0, 32'hFF_FFFF)), 8'h00} | 32'(val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(REG_WINDOW_RADIUS) << 2; pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
    radius = val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[RadiusW-1:0] !== val) begin
      $display("%0t radius readback: expected %0d actual %0d", $time, val, prdata[RadiusW-1:0]);
      errors++;
    end
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CoordW-1:0] clip(longint v);
    if (v < 0) return '0;
    if (v > longint'(CoordMax)) return CoordMax;
    return CoordW'(v);
  endfunction

  // Ascending chrom-then-start load with the odd out-of-order entry
  task automatic load_table(input int n);
    query_item_t it;
    longint pos;
    int chrom;
    chrom = $urandom_range(0, 3);
    pos = $urandom_range(0, 3) == 0 ? longint'(CoordMax) - 20000 : $urandom_range(0, 5000);
    for (int k = 0; k < n; k++) begin
      it.func   = FUNC_APPEND;
      it.single = 1'($urandom_range(0, 1));
      it.strand = StrandW'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0 && chrom < 255) begin
        chrom = (chrom + $urandom_range(1, 60) > 255) ? 255 : chrom + $urandom_range(1, 60);
        pos = $urandom_range(0, 3) == 0 ? longint'(CoordMax) - 20000 : $urandom_range(0, 5000);
      end
      pos += $urandom_range(0, 300);
      it.chrom     = ChromW'(chrom);
      it.start_pos = clip(pos);
      it.end_pos   = clip(pos + $urandom_range(0, 800));
      if ($urandom_range(0, 19) == 0) begin
        it.chrom     = ChromW'($urandom);
        it.start_pos = CoordW'($urandom);
        it.end_pos   = CoordW'($urandom);
      end
      send_item(it, 1'b0);
    end
  endtask

  task automatic random_queries(input int n);
    query_item_t it;
    int sel, k;
    longint s;
    for (int q = 0; q < n; q++) begin
      sel = $urandom_range(0, 99);
      it.func   = FUNC_QUERY;
      it.strand = StrandW'($urandom_range(0, 3));
      it.single = 1'b1;
      if (tbl_count > 0 && sel < 86) begin
        k = $urandom_range(0, tbl_count - 1);
        it.chrom = tbl_chrom[k];
        s = longint'(tbl_start[k]) + $urandom_range(0, 400) - 200;
        it.start_pos = clip(s);
        if (sel < 76) it.end_pos = clip(s + $urandom_range(1, 1000));
        else it.end_pos = clip(s - $urandom_range(0, 300));     // reversed query
        if (sel >= 80) it.single = 1'b0;                        // multi-block
      end else begin
        it.chrom     = ChromW'($urandom);
        it.start_pos = CoordW'($urandom);
        it.end_pos   = CoordW'($urandom);
        it.single    = 1'($urandom_range(0, 1));
        if (sel >= 95) it.func = FUNC_NOP;                      // unused func
      end
      send_item(it, 1'b0);
    end
  endtask

  // Receiver: pattern of its own, plus one long hold-off on request
  int hold_left;
  int rx_mode, rx_cnt;
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = 600;
      hold_start = 1'b0;
    end
    if (rx_cnt == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_cnt = $urandom_range(20, 200);
    end
    rx_cnt--;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= $urandom_range(0, 1);
        default: rsp.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result check, mid-cycle, against the oldest expectation
  always @(negedge clk) begin
    overlap_res_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result transaction: actual hit %0b index %0d", $time,
                 rsp.hit, rsp.entry_index);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (rsp.hit !== e.hit) begin
          $display("%0t hit: expected %0b actual %0b", $time, e.hit, rsp.hit); errors++;
        end
        if (rsp.entry_index !== e.index) begin
          $display("%0t entry_index: expected %0d actual %0d", $time, e.index, rsp.entry_index);
          errors++;
        end
        if (rsp.entry_strand !== e.strand) begin
          $display("%0t entry_strand: expected %0d actual %0d", $time, e.strand,
                   rsp.entry_strand);
          errors++;
        end
        if (rsp.overlap_length !== e.overlap) begin
          $display("%0t overlap_length: expected %0d actual %0d", $time, e.overlap,
                   rsp.overlap_length);
          errors++;
        end
        if (rsp.ratio_of_query !== e.ratio_q) begin
          $display("%0t ratio_of_query: expected %0d actual %0d", $time, e.ratio_q,
                   rsp.ratio_of_query);
          errors++;
        end
        if (rsp.ratio_of_entry !== e.ratio_e) begin
          $display("%0t ratio_of_entry: expected %0d actual %0d", $time, e.ratio_e,
                   rsp.ratio_of_entry);
          errors++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("interval_best_overlap_search_unit test failed");
    $finish;
  end

  dir_row_t dir_rows[$];

  function automatic void add_row(logic [FuncW-1:0] f, logic [ChromW-1:0] c,
                                  logic [CoordW-1:0] s, logic [CoordW-1:0] e,
                                  logic [StrandW-1:0] st, logic sb, logic miss);
    dir_row_t d;
    d.item = '{f, c, s, e, st, sb};
    d.typed_miss = miss;
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  initial begin
    int radii[6];
    errors = 0;
    tbl_count = 0;
    radius = RadiusReset;
    burst_left = 0;
    hold_start = 1'b0;
    hold_left = 0;
    rx_cnt = 0;
    req.valid = 1'b0; req.func = FUNC_APPEND; req.chrom_id = '0; req.item_start = '0;
    req.item_end = '0; req.item_strand = '0; req.single_block = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset radius
    add_row(FUNC_QUERY,  8'd5,   31'd100, 31'd200, 2'd0, 1'b1, 1'b1); // empty
    add_row(FUNC_APPEND, 8'd5,   31'd100, 31'd200, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_APPEND, 8'd5,   31'd150, 31'd400, 2'd1, 1'b0, 1'b0);
    add_row(FUNC_APPEND, 8'd5,   31'd1000, 31'd1100, 2'd2, 1'b1, 1'b0);
    add_row(FUNC_APPEND, 8'd255, CoordMax - 31'd255, CoordMax, 2'd3, 1'b0, 1'b0);
    add_row(FUNC_QUERY,  8'd5,   31'd120, 31'd180, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_QUERY,  8'd5,   31'd120, 31'd180, 2'd0, 1'b0, 1'b1); // multi
    add_row(FUNC_QUERY,  8'd5,   31'd300, 31'd100, 2'd1, 1'b1, 1'b0); // reversed
    add_row(FUNC_QUERY,  8'd255, 31'd0,   CoordMax, 2'd2, 1'b1, 1'b0);
    add_row(FUNC_QUERY,  8'd0,   31'd0,   31'd0,    2'd0, 1'b1, 1'b1); // no chrom
    add_row(FUNC_NOP,    8'd5,   31'd120, 31'd180, 2'd0, 1'b1, 1'b0); // unused
    add_row(FUNC_QUERY,  8'd5,   31'd0,   CoordMax, 2'd3, 1'b1, 1'b0);
    add_row(FUNC_QUERY,  8'd5,   31'd200, 31'd1000, 2'd0, 1'b1, 1'b0); // touching
    add_row(FUNC_CLEAR,  8'd0,   31'd0,   31'd0,    2'd0, 1'b0, 1'b0);
    add_row(FUNC_QUERY,  8'd5,   31'd120, 31'd180, 2'd0, 1'b1, 1'b1); // cleared
    add_row(FUNC_APPEND, 8'd0,   31'd0,   CoordMax, 2'd1, 1'b1, 1'b0);
    add_row(FUNC_QUERY,  8'd0,   31'd0,   CoordMax, 2'd0, 1'b1, 1'b0);
    add_row(FUNC_QUERY,  8'd0,   CoordMax, 31'd0,   2'd0, 1'b1, 1'b1);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed_miss);
    drain();

    // Random phases over several radii, the extremes among them
    radii = '{50, 0, 255, 1, 7, 0};
    radii[5] = $urandom_range(0, 255);
    for (int p = 0; p < 6; p++) begin
      set_radius(RadiusW'(radii[p]));
      send_item(query_item_t'{FUNC_CLEAR, 8'd0, 31'd0, 31'd0, 2'd0, 1'b0}, 1'b0);
      if (p == 2) begin
        load_table(600);         // large table: up to ten search probes
        random_queries(60);
      end else begin
        load_table($urandom_range(1, 40));
        if (p == 1) hold_start = 1'b1;   // long receiver hold-off under load
        random_queries(30);
      end
      drain();                   // sender pauses until every result is in
    end

    if (errors == 0) begin
      $display("interval_best_overlap_search_unit test passed");
    end else begin
      $display("interval_best_overlap_search_unit test failed");
    end
    $finish;
  end

endmodule
